// File: design/vals_pkg.sv
`timescale 1ns / 1ps

package vals_pkg;

	localparam int DATA_W = 32;

	typedef struct packed {
		logic signed [DATA_W-1:0] position;
		logic signed [DATA_W-1:0] velocity;
		logic signed [DATA_W-1:0] sound_speed;
		logic signed [DATA_W-1:0] pressure;
		logic                     grid_start;
	} in_word_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] velocity_slope;
		logic signed [DATA_W-1:0] sound_speed_slope;
		logic signed [DATA_W-1:0] pressure_slope;
		logic                     spacing_error;
		logic                     saturated;
	} out_word_t;

	typedef struct packed {
		logic                   start;
		logic signed [DATA_W:0] dl;
		logic signed [DATA_W:0] dr;
		logic [DATA_W-1:0]      dxl;
		logic [DATA_W-1:0]      dxr;
	} lane_cmd_t;

	typedef struct packed {
		logic                     done;
		logic                     sat;
		logic signed [DATA_W-1:0] slope;
	} lane_stat_t;

	typedef enum logic [2:0] {
		L_IDLE,
		L_DIVA,
		L_DIVB,
		L_MUL1,
		L_MUL2,
		L_MUL3,
		L_DIVL,
		L_DONE
	} lane_state_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_HOLD
	} top_state_t;

endpackage

// File: design/vals_div.sv
`timescale 1ns / 1ps

module vals_div #(
	parameter int NW = 96,
	parameter int DW = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [NW-1:0] dividend,
	input  logic [DW-1:0] divisor,
	output logic          busy,
	output logic [NW-1:0] quotient
);

	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [DW-1:0] dsr_q;
	logic [DW-1:0] rem_q;
	logic [NW-1:0] quo_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [DW:0]   trial;
	logic [DW:0]   diff;
	logic          ge;

	assign trial = {rem_q, dvd_q[NW-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign ge    = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			busy_q <= (cnt_q != CW'(1));
			cnt_q  <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

	// the remainder always stays below the divisor
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < dsr_q)
		else $error("remainder not below divisor");

	a_cnt_live: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> cnt_q != '0)
		else $error("divider busy with zero count");

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("divider restarted while busy");

endmodule

// File: design/vals_lane.sv
`timescale 1ns / 1ps

module vals_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  vals_pkg::lane_cmd_t  cmd,
	output vals_pkg::lane_stat_t stat
);

	import vals_pkg::*;

	localparam int W  = DATA_W;
	localparam int NW = 3 * W;
	localparam int DW = 2 * W;
	localparam logic [NW-1:0] MAXP = {{(NW-W+1){1'b0}}, {(W-1){1'b1}}};
	localparam logic [NW-1:0] MAXN = MAXP + NW'(1);

	lane_state_t state_q, state_d;

	logic signed [W:0]   dl_q, dr_q;
	logic [W-1:0]        dxl_q, dxr_q;
	logic signed [W-1:0] a_q, b_q, res_q;
	logic                sat_q;
	logic [DW-1:0]       sqa_s1, sqb_s1, pab_s1;
	logic [DW-1:0]       den_s2;
	logic [DW:0]         plo_s2, phi_s2;

	logic          div_start;
	logic [NW-1:0] div_dvd;
	logic [DW-1:0] div_dsr;
	logic          div_busy;
	logic [NW-1:0] div_quo;

	logic [W:0]          mag_l, mag_r;
	logic signed [W:0]   sum_w;
	logic [W-1:0]        ma, mb;
	logic [W:0]          ms;
	logic                lim_neg, zero_hit;
	logic                q_neg, q_sat;
	logic signed [W-1:0] q_val;

	assign mag_l   = dl_q[W] ? -dl_q : dl_q;
	assign mag_r   = dr_q[W] ? -dr_q : dr_q;
	assign sum_w   = {a_q[W-1], a_q} + {b_q[W-1], b_q};
	assign ma      = a_q[W-1] ? -a_q : a_q;
	assign mb      = b_q[W-1] ? -b_q : b_q;
	assign ms      = sum_w[W] ? -sum_w : sum_w;
	assign lim_neg = a_q[W-1] ^ b_q[W-1] ^ sum_w[W];
	assign zero_hit = (a_q == '0) || (b_q == '0) || (sum_w == '0);

	// sign and clip of the divider quotient
	always_comb begin
		unique case (state_q)
			L_DIVA:  q_neg = dl_q[W];
			L_DIVB:  q_neg = dr_q[W];
			default: q_neg = lim_neg;
		endcase
		q_sat = q_neg ? (div_quo > MAXN) : (div_quo > MAXP);
		if (q_sat) begin
			q_val = q_neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		end else begin
			q_val = q_neg ? -div_quo[W-1:0] : div_quo[W-1:0];
		end
	end

	always_comb begin
		state_d   = state_q;
		div_start = 1'b0;
		div_dvd   = NW'(mag_l) << FRAC_BITS;
		div_dsr   = DW'(dxl_q);
		unique case (state_q)
			L_IDLE, L_DONE: begin
				if (cmd.start) state_d = L_DIVA;
			end
			L_DIVA: begin
				if (!div_busy) begin
					div_start = 1'b1;
					div_dvd   = NW'(mag_r) << FRAC_BITS;
					div_dsr   = DW'(dxr_q);
					state_d   = L_DIVB;
				end
			end
			L_DIVB: begin
				if (!div_busy) state_d = L_MUL1;
			end
			L_MUL1: begin
				state_d = zero_hit ? L_DONE : L_MUL2;
			end
			L_MUL2: begin
				state_d = L_MUL3;
			end
			L_MUL3: begin
				div_start = 1'b1;
				div_dvd   = (NW'(phi_s2) << W) + NW'(plo_s2);
				div_dsr   = den_s2;
				state_d   = L_DIVL;
			end
			L_DIVL: begin
				if (!div_busy) state_d = L_DONE;
			end
			default: state_d = L_IDLE;
		endcase
		if ((state_q == L_IDLE || state_q == L_DONE) && cmd.start) begin
			div_start = 1'b1;
			div_dvd   = NW'(cmd.dl[W] ? -cmd.dl : cmd.dl) << FRAC_BITS;
			div_dsr   = DW'(cmd.dxl);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == L_IDLE || state_q == L_DONE) && cmd.start) begin
			dl_q  <= cmd.dl;
			dr_q  <= cmd.dr;
			dxl_q <= cmd.dxl;
			dxr_q <= cmd.dxr;
			sat_q <= 1'b0;
		end
		if (state_q == L_DIVA && !div_busy) begin
			a_q   <= q_val;
			sat_q <= sat_q | q_sat;
		end
		if (state_q == L_DIVB && !div_busy) begin
			b_q   <= q_val;
			sat_q <= sat_q | q_sat;
		end
		if (state_q == L_MUL1) begin
			sqa_s1 <= ma * ma;
			sqb_s1 <= mb * mb;
			pab_s1 <= ma * mb;
			res_q  <= '0;
		end
		if (state_q == L_MUL2) begin
			den_s2 <= sqa_s1 + sqb_s1 + DW'(1);
			plo_s2 <= pab_s1[W-1:0] * ms;
			phi_s2 <= pab_s1[DW-1:W] * ms;
		end
		if (state_q == L_DIVL && !div_busy) begin
			res_q <= q_val;
			sat_q <= sat_q | q_sat;
		end
	end

	vals_div #(
		.NW(NW),
		.DW(DW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dsr),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	assign stat.done  = (state_q == L_DONE);
	assign stat.sat   = sat_q;
	assign stat.slope = res_q;

endmodule

// File: design/van_albada_slope_limiter.sv
`timescale 1ns / 1ps
// a result word follows each accepted word that completes a window of three points; it is set by three
// 96-step restoring divisions run one after another in each lane (two slopes, then the limiter),
// and the limiter division is skipped in a lane that finds a zero slope or a zero slope sum
// no new word is taken while a result is computed or held; words that only fill the window leave it ready
// a word with bad spacing skips the lanes and goes to the hold state, then to the output register
// reset: asynchronous, clears the window, the point count and all handshake state

module van_albada_slope_limiter #(
	parameter int FRAC_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  vals_pkg::in_word_t  item,
	output logic                result_valid,
	input  logic                result_ready,
	output vals_pkg::out_word_t result
);

	import vals_pkg::*;

	localparam int W = DATA_W;

	top_state_t state_q, state_d;

	logic signed [W-1:0] wx_q [2];
	logic signed [W-1:0] wv_q [3][2];
	logic [1:0]          pts_q;
	out_word_t           res_q;
	out_word_t           out_q;
	logic                out_valid_q;

	logic                accept, load;
	logic signed [W:0]   dxl, dxr;
	logic                bad;
	logic signed [W-1:0] cur [3];
	lane_cmd_t           cmd [3];
	lane_stat_t          stat [3];
	logic                all_done;

	assign cur[0] = item.velocity;
	assign cur[1] = item.sound_speed;
	assign cur[2] = item.pressure;

	assign item_ready = (state_q == S_IDLE);
	assign accept     = item_valid && item_ready;
	assign load       = (state_q == S_HOLD) && (!out_valid_q || result_ready);

	assign dxl = {wx_q[1][W-1], wx_q[1]} - {wx_q[0][W-1], wx_q[0]};
	assign dxr = {item.position[W-1], item.position} - {wx_q[1][W-1], wx_q[1]};
	assign bad = dxl[W] || (dxl == '0) || dxr[W] || (dxr == '0);

	assign all_done = stat[0].done && stat[1].done && stat[2].done;

	for (genvar k = 0; k < 3; k++) begin : g_lane
		assign cmd[k].start = accept && !item.grid_start && (pts_q == 2'd2) && !bad;
		assign cmd[k].dl    = {wv_q[k][1][W-1], wv_q[k][1]} - {wv_q[k][0][W-1], wv_q[k][0]};
		assign cmd[k].dr    = {cur[k][W-1], cur[k]} - {wv_q[k][1][W-1], wv_q[k][1]};
		assign cmd[k].dxl   = dxl[W-1:0];
		assign cmd[k].dxr   = dxr[W-1:0];

		vals_lane #(
			.FRAC_BITS(FRAC_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cmd    (cmd[k]),
			.stat   (stat[k])
		);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && !item.grid_start && pts_q == 2'd2) begin
					state_d = bad ? S_HOLD : S_RUN;
				end
			end
			S_RUN: begin
				if (all_done) state_d = S_HOLD;
			end
			S_HOLD: begin
				if (load) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			pts_q       <= '0;
			out_valid_q <= 1'b0;
			wx_q[0]     <= '0;
			wx_q[1]     <= '0;
			for (int k = 0; k < 3; k++) begin
				wv_q[k][0] <= '0;
				wv_q[k][1] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (accept) begin
				wx_q[0] <= item.grid_start ? '0 : wx_q[1];
				wx_q[1] <= item.position;
				for (int k = 0; k < 3; k++) begin
					wv_q[k][0] <= item.grid_start ? '0 : wv_q[k][1];
					wv_q[k][1] <= cur[k];
				end
				if (item.grid_start) begin
					pts_q <= 2'd1;
				end else if (pts_q != 2'd2) begin
					pts_q <= pts_q + 2'd1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (result_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result word: the spacing error word or the merge of the three lanes, then the output register
	always_ff @(posedge clk) begin
		if (accept && bad) begin
			res_q <= '{velocity_slope: '0, sound_speed_slope: '0, pressure_slope: '0,
				spacing_error: 1'b1, saturated: 1'b0};
		end else if (state_q == S_RUN && all_done) begin
			res_q <= '{velocity_slope: stat[0].slope, sound_speed_slope: stat[1].slope,
				pressure_slope: stat[2].slope, spacing_error: 1'b0,
				saturated: stat[0].sat || stat[1].sat || stat[2].sat};
		end
		if (load) begin
			out_q <= res_q;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.spacing_error |->
			!out_q.saturated && out_q.velocity_slope == '0 &&
			out_q.sound_speed_slope == '0 && out_q.pressure_slope == '0)
		else $error("spacing error word with non-zero payload");

	a_start_fill: assert property (@(posedge clk) disable iff (!arst_n)
		accept && item.grid_start |=> state_q == S_IDLE && pts_q == 2'd1)
		else $error("grid start did not restart the window");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !result_ready |=> out_valid_q && $stable(out_q))
		else $error("result word dropped or changed while waiting");

	a_lanes_sync: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(state_q == S_RUN) |-> !stat[0].done && !stat[1].done && !stat[2].done)
		else $error("lane reported done at start of run");

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
	import vals_pkg::*;

	localparam int FRAC = 16;
	localparam longint SMAX = 64'sd2147483647;
	localparam longint SMIN = -64'sd2147483648;
	localparam int WATCHDOG = 20000;
	localparam int SETTLE = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic item_valid = 1'b0;
	logic item_ready;
	in_word_t item = '0;
	logic result_valid;
	logic result_ready = 1'b0;
	out_word_t result;

	in_word_t pending_words[$];
	out_word_t expected_slopes[$];
	logic signed [31:0] win_pos[2];
	logic signed [31:0] win_vel[2];
	logic signed [31:0] win_snd[2];
	logic signed [31:0] win_prs[2];
	int held_points;
	int mismatches = 0;
	int idle_cycles = 0;
	int send_gap = 0;
	int recv_gap = 0;
	int long_hold = 0;
	bit stim_done = 1'b0;
	bit drain_req = 1'b0;

	always #5 clk = ~clk;

	van_albada_slope_limiter u_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result)
	);

	function automatic longint clip(longint v, ref bit sat);
		if (v > SMAX) begin
			sat = 1'b1;
			return SMAX;
		end
		if (v < SMIN) begin
			sat = 1'b1;
			return SMIN;
		end
		return v;
	endfunction

	function automatic longint side_slope(longint d, longint dx, ref bit sat);
		longint m;
		longint q;
		m = d < 0 ? -d : d;
		q = (m <<< FRAC) / dx;
		return clip(d < 0 ? -q : q, sat);
	endfunction

	function automatic longint albada(longint a, longint b, ref bit sat);
		logic signed [127:0] num;
		logic signed [127:0] den;
		logic signed [127:0] q;
		longint s;
		s = a + b;
		if (a == 0 || b == 0 || s == 0)
			return 0;
		num = 128'(a) * 128'(b) * 128'(s);
		den = 128'(a) * 128'(a) + 128'(b) * 128'(b) + 128'sd1;
		q = num / den;
		if (q > 128'(SMAX)) begin
			sat = 1'b1;
			return SMAX;
		end
		if (q < 128'(SMIN)) begin
			sat = 1'b1;
			return SMIN;
		end
		return longint'(q);
	endfunction

	task automatic predict_slopes(in_word_t w);
		out_word_t r;
		longint dxl;
		longint dxr;
		longint a;
		longint b;
		longint cur[3];
		longint older[3];
		longint newer[3];
		longint res;
		bit sat;
		sat = 1'b0;
		r = '0;
		if (w.grid_start || held_points < 2) begin
			held_points = w.grid_start ? 1 : held_points + 1;
		end else begin
			dxl = longint'(win_pos[1]) - longint'(win_pos[0]);
			dxr = longint'(w.position) - longint'(win_pos[1]);
			cur = '{w.velocity, w.sound_speed, w.pressure};
			older = '{win_vel[0], win_snd[0], win_prs[0]};
			newer = '{win_vel[1], win_snd[1], win_prs[1]};
			if (dxl <= 0 || dxr <= 0) begin
				r.spacing_error = 1'b1;
			end else begin
				for (int k = 0; k < 3; k++) begin
					a = side_slope(newer[k] - older[k], dxl, sat);
					b = side_slope(cur[k] - newer[k], dxr, sat);
					res = albada(a, b, sat);
					if (k == 0) r.velocity_slope = res[31:0];
					else if (k == 1) r.sound_speed_slope = res[31:0];
					else r.pressure_slope = res[31:0];
				end
				r.saturated = sat;
			end
			expected_slopes.push_back(r);
		end
		// a grid start clears the older entry
		win_pos[0] = w.grid_start ? '0 : win_pos[1]; win_pos[1] = w.position;
		win_vel[0] = w.grid_start ? '0 : win_vel[1]; win_vel[1] = w.velocity;
		win_snd[0] = w.grid_start ? '0 : win_snd[1]; win_snd[1] = w.sound_speed;
		win_prs[0] = w.grid_start ? '0 : win_prs[1]; win_prs[1] = w.pressure;
	endtask

	function automatic logic [31:0] rand_value();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return $urandom_range(0, 8) << 16;
			3: return $urandom;
			default: return 32'($signed($urandom_range(0, 2000)) - 1000) << $urandom_range(0, 20);
		endcase
	endfunction

	task automatic add_word(logic [31:0] x, logic [31:0] u, logic [31:0] c, logic [31:0] p,
			logic s);
		in_word_t w;
		w.position = x;
		w.velocity = u;
		w.sound_speed = c;
		w.pressure = p;
		w.grid_start = s;
		pending_words.push_back(w);
	endtask

	// driver
	always @(posedge clk) begin
		if (item_valid && item_ready) begin
			predict_slopes(item);
		end
		if (!item_valid || item_ready) begin
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				item_valid <= 1'b0;
			end else if (drain_req && pending_words.size() > 0 &&
					pending_words[0].grid_start === 1'bx) begin
				item_valid <= 1'b0;
			end else if (pending_words.size() > 0 && arst_n) begin
				item <= pending_words.pop_front();
				item_valid <= 1'b1;
				send_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		out_word_t e;
		if (result_valid && result_ready) begin
			if (expected_slopes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", result);
			end else begin
				e = expected_slopes.pop_front();
				if (result !== e) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h %h %h e%b s%b, got %h %h %h e%b s%b",
							e.velocity_slope, e.sound_speed_slope, e.pressure_slope,
							e.spacing_error, e.saturated, result.velocity_slope,
							result.sound_speed_slope, result.pressure_slope,
							result.spacing_error, result.saturated);
				end
			end
		end
		if (long_hold > 0) begin
			long_hold <= long_hold - 1;
			result_ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= 1'b1;
			if (result_valid && result_ready)
				recv_gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 16) : 0;
		end
	end

	// watchdog
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG) begin
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	initial begin
		logic [31:0] x;
		held_points = 0;
		for (int i = 0; i < 2; i++) begin
			win_pos[i] = '0; win_vel[i] = '0; win_snd[i] = '0; win_prs[i] = '0;
		end
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: points without a start, grid starts, bad spacing, smooth and extreme values
		add_word(32'h0001_0000, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 1'b0);
		add_word(32'h0002_0000, 32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 1'b0);
		add_word(32'h0003_0000, 32'h0004_0000, 32'h0002_0000, 32'hffff_0000, 1'b0);
		add_word(32'h0003_0000, 32'h0004_0000, 32'h0002_0000, 32'h0000_0000, 1'b0);
		add_word(32'h0002_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b1);
		add_word(32'h0002_0001, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
		add_word(32'h0002_0002, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0);
		add_word(32'h0002_0003, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 1'b0);
		add_word(32'h8000_0000, 32'h0, 32'h0, 32'h0, 1'b1);
		add_word(32'h0000_0000, 32'h0001_0000, 32'hffff_ffff, 32'h0000_0001, 1'b0);
		add_word(32'h7fff_ffff, 32'h0002_0000, 32'h0000_0001, 32'hffff_ffff, 1'b0);
		add_word(32'h7fff_ffff, 32'h0002_0000, 32'h0, 32'h0, 1'b0);
		add_word(32'h0000_0000, 32'h0005_0000, 32'h0005_0000, 32'h0005_0000, 1'b1);
		add_word(32'h0004_0000, 32'h0001_0000, 32'h0009_0000, 32'h0005_0000, 1'b0);
		add_word(32'h0008_0000, 32'hfffd_0000, 32'h0005_0000, 32'h0005_0000, 1'b0);
		add_word(32'h000c_0000, 32'hfffd_0000, 32'h0001_0000, 32'h0007_0000, 1'b0);

		// hold the receiver so the block backs up
		wait (pending_words.size() < 8);
		long_hold = 1500;
		for (int k = 0; k < 20; k++) begin
			x = $urandom_range(0, 64) << 16;
			add_word(x + k * 32'h0001_8000, rand_value(), rand_value(), rand_value(), k == 0);
		end
		wait (pending_words.size() == 0);

		for (int g = 0; g < 370; g++) begin
			int len;
			len = $urandom_range(1, 8);
			// sender stops until every expected result has come
			if (g == 150) begin
				wait (pending_words.size() == 0);
				@(posedge clk);
				wait (!item_valid);
				wait (expected_slopes.size() == 0);
			end
			x = rand_value();
			for (int k = 0; k < len; k++) begin
				add_word(x, rand_value(), rand_value(), rand_value(),
					k == 0 && $urandom_range(0, 4) != 0);
				if ($urandom_range(0, 7) == 0)
					x = rand_value();
				else
					x = x + ($urandom_range(1, 1 << $urandom_range(0, 20)) << $urandom_range(0, 8));
			end
			wait (pending_words.size() < 16);
		end
		wait (pending_words.size() == 0);
		@(posedge clk);
		wait (!item_valid);
		wait (expected_slopes.size() == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && expected_slopes.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
